>>> sv/rima_pkg.sv
package rima_pkg;

  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_FOLLOW = 2'd1,
    MODE_MECH   = 2'd2,
    MODE_SPIN   = 2'd3
  } mode_t;

  localparam logic [1:0] SW_INVALID = 2'd0;
  localparam logic [1:0] SW_DOWN    = 2'd2;

  localparam int KEY_W     = 0;
  localparam int KEY_S     = 1;
  localparam int KEY_A     = 2;
  localparam int KEY_D     = 3;
  localparam int KEY_SHIFT = 4;
  localparam int KEY_CTRL  = 5;
  localparam int KEY_Q     = 6;
  localparam int KEY_F     = 9;
  localparam int KEY_G     = 10;
  localparam int KEY_Z     = 11;
  localparam int KEY_X     = 12;
  localparam int KEY_C     = 13;
  localparam int KEY_V     = 14;

  typedef enum logic [2:0] {
    REG_SPIN_REARM   = 3'd0,
    REG_SPIN_TRIGGER = 3'd1,
    REG_TURN_REARM   = 3'd2,
    REG_TURN_TRIGGER = 3'd3,
    REG_MOVE_NORMAL  = 3'd4,
    REG_MOVE_SLOW    = 3'd5,
    REG_MOVE_SPRINT  = 3'd6,
    REG_YAW_GAIN     = 3'd7
  } reg_idx_t;

  // front-to-back record: mouse products still to be clamped
  typedef struct packed {
    logic               online;
    mode_t              mode;
    logic signed [10:0] yaw;
    logic signed [10:0] pitch;
    logic signed [10:0] strafe;
    logic signed [10:0] forward;
    logic signed [10:0] wheel;
    logic               kb_map;
    logic signed [23:0] mx_prod;
    logic signed [23:0] my_prod;
    logic               spin;
    logic               kb_on;
    logic [31:0]        turns;
  } frame_t;

endpackage

>>> sv/remote_input_mode_arbiter.sv
// Result path: a taken input is registered in the front register, then queued.
// Throughput: one frame per cycle while the queue has room; front state updates on each taken input.
// Input ready drops only when the two-entry queue plus front register are full.
// Reset (rst, synchronous): clears all mode flags, turnaround count and queue,
// and loads register defaults.
module remote_input_mode_arbiter #(
  parameter int AIM_DIVISOR   = 4,
  parameter int PITCH_GAIN    = 1,
  parameter int FOLLOW_POS    = 3,
  parameter int MECH_POS      = 1,
  parameter int MECH_DOWN_POS = 2,
  parameter int SPIN_ON_POS   = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [9:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               link_online,
  input  logic signed [10:0] stick_right_x,
  input  logic signed [10:0] stick_right_y,
  input  logic signed [10:0] stick_left_x,
  input  logic signed [10:0] stick_left_y,
  input  logic signed [10:0] dial_wheel,
  input  logic [1:0]         left_switch,
  input  logic [1:0]         right_switch,
  input  logic [15:0]        key_bitmap,
  input  logic signed [15:0] mouse_dx,
  input  logic signed [15:0] mouse_dy,
  input  logic               mouse_right_button,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_online,
  output logic [1:0]         chassis_mode,
  output logic signed [10:0] out_yaw,
  output logic signed [10:0] out_pitch,
  output logic signed [10:0] out_strafe,
  output logic signed [10:0] out_forward,
  output logic signed [10:0] out_wheel,
  output logic               rotate_enable,
  output logic               keyboard_mode_on,
  output logic [31:0]        turnaround_total
);

  rima_pkg::frame_t frame;
  logic f_valid, q_full, push, in_take;

  assign push     = f_valid && !q_full;
  assign in_ready = !f_valid || !q_full;
  assign in_take  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) f_valid <= 1'b0;
    else if (in_take) f_valid <= 1'b1;
    else if (push) f_valid <= 1'b0;
  end

  rima_front #(
    .AIM_DIVISOR(AIM_DIVISOR), .PITCH_GAIN(PITCH_GAIN), .FOLLOW_POS(FOLLOW_POS),
    .MECH_POS(MECH_POS), .MECH_DOWN_POS(MECH_DOWN_POS), .SPIN_ON_POS(SPIN_ON_POS)
  ) u_front (
    .clk, .rst, .cfg_we, .cfg_idx, .cfg_data, .in_take,
    .link_online, .stick_right_x, .stick_right_y, .stick_left_x, .stick_left_y,
    .dial_wheel, .left_switch, .right_switch, .key_bitmap, .mouse_dx, .mouse_dy,
    .mouse_right_button, .frame
  );

  rima_back u_back (
    .clk, .rst, .push, .frame, .full(q_full), .valid(out_valid), .ready(out_ready),
    .out_online, .chassis_mode, .out_yaw, .out_pitch, .out_strafe, .out_forward,
    .out_wheel, .rotate_enable, .keyboard_mode_on, .turnaround_total
  );

endmodule

>>> sv/rima_front.sv
module rima_front #(
  parameter int AIM_DIVISOR   = 4,
  parameter int PITCH_GAIN    = 1,
  parameter int FOLLOW_POS    = 3,
  parameter int MECH_POS      = 1,
  parameter int MECH_DOWN_POS = 2,
  parameter int SPIN_ON_POS   = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [9:0]         cfg_data,
  input  logic               in_take,
  input  logic               link_online,
  input  logic signed [10:0] stick_right_x,
  input  logic signed [10:0] stick_right_y,
  input  logic signed [10:0] stick_left_x,
  input  logic signed [10:0] stick_left_y,
  input  logic signed [10:0] dial_wheel,
  input  logic [1:0]         left_switch,
  input  logic [1:0]         right_switch,
  input  logic [15:0]        key_bitmap,
  input  logic signed [15:0] mouse_dx,
  input  logic signed [15:0] mouse_dy,
  input  logic               mouse_right_button,
  output rima_pkg::frame_t   frame
);

  logic [9:0] spin_rearm, spin_trig, turn_rearm, turn_trig;
  logic [9:0] mv_normal, mv_slow, mv_sprint;
  logic [6:0] yaw_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      spin_rearm <= 10'd100;
      spin_trig  <= 10'd500;
      turn_rearm <= 10'd100;
      turn_trig  <= 10'd500;
      mv_normal  <= 10'd440;
      mv_slow    <= 10'd200;
      mv_sprint  <= 10'd660;
      yaw_gain   <= 7'd1;
    end else if (cfg_we) begin
      unique case (rima_pkg::reg_idx_t'(cfg_idx))
        rima_pkg::REG_SPIN_REARM:   spin_rearm <= cfg_data;
        rima_pkg::REG_SPIN_TRIGGER: spin_trig  <= cfg_data;
        rima_pkg::REG_TURN_REARM:   turn_rearm <= cfg_data;
        rima_pkg::REG_TURN_TRIGGER: turn_trig  <= cfg_data;
        rima_pkg::REG_MOVE_NORMAL:  mv_normal  <= cfg_data;
        rima_pkg::REG_MOVE_SLOW:    mv_slow    <= cfg_data;
        rima_pkg::REG_MOVE_SPRINT:  mv_sprint  <= cfg_data;
        rima_pkg::REG_YAW_GAIN:     yaw_gain   <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  logic turn_armed, spin_sw_seen, spin_sw_armed, wheel_ready, wheel_spin_sel;
  logic keys_seen, kb_active, kb_g_rel, kb_spin_armed, kb_q_rel, kb_f_rel, kb_friction;
  logic [31:0] turn_count;
  logic [1:0] spin_sw_last, left_sw_last;
  logic [15:0] keys_last;
  rima_pkg::mode_t kb_mode;

  logic turn_armed_next, spin_sw_seen_next, spin_sw_armed_next, wheel_ready_next;
  logic wheel_spin_sel_next, keys_seen_next, kb_active_next, kb_g_rel_next;
  logic kb_spin_armed_next, kb_q_rel_next, kb_f_rel_next, kb_friction_next;
  logic [31:0] turn_count_next;
  logic [1:0] spin_sw_last_next, left_sw_last_next;
  logic [15:0] keys_last_next;
  rima_pkg::mode_t kb_mode_next;
  rima_pkg::frame_t f;

  always_ff @(posedge clk) begin
    if (rst) begin
      turn_armed <= 1'b0; turn_count <= '0; spin_sw_seen <= 1'b0;
      spin_sw_last <= '0; spin_sw_armed <= 1'b0; wheel_ready <= 1'b0;
      wheel_spin_sel <= 1'b0; left_sw_last <= '0; keys_seen <= 1'b0;
      keys_last <= '0; kb_active <= 1'b0; kb_mode <= rima_pkg::MODE_OFF;
      kb_g_rel <= 1'b0; kb_spin_armed <= 1'b0; kb_q_rel <= 1'b0;
      kb_f_rel <= 1'b0; kb_friction <= 1'b0;
    end else if (in_take) begin
      turn_armed <= turn_armed_next; turn_count <= turn_count_next;
      spin_sw_seen <= spin_sw_seen_next; spin_sw_last <= spin_sw_last_next;
      spin_sw_armed <= spin_sw_armed_next; wheel_ready <= wheel_ready_next;
      wheel_spin_sel <= wheel_spin_sel_next; left_sw_last <= left_sw_last_next;
      keys_seen <= keys_seen_next; keys_last <= keys_last_next;
      kb_active <= kb_active_next; kb_mode <= kb_mode_next;
      kb_g_rel <= kb_g_rel_next; kb_spin_armed <= kb_spin_armed_next;
      kb_q_rel <= kb_q_rel_next; kb_f_rel <= kb_f_rel_next;
      kb_friction <= kb_friction_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) frame <= f;
  end

  localparam logic [24:0] AIM_RECIP = 25'(((64'd1 << 24) + 64'(AIM_DIVISOR) - 64'd1)
                                          / 64'(AIM_DIVISOR));

  // truncating divide by AIM_DIVISOR through a reciprocal multiply, exact for 16 bits
  function automatic logic signed [15:0] aim_div(input logic signed [15:0] v);
    logic [15:0] mag;
    logic [40:0] prod;
    logic [15:0] q;
    mag = v[15] ? 16'(-v) : 16'(v);
    prod = mag * AIM_RECIP;
    q = prod[39:24];
    return v[15] ? -$signed(q) : $signed(q);
  endfunction

  logic [15:0] pressed;
  logic online;
  rima_pkg::mode_t mode, kb_before;
  logic signed [11:0] wheel12, ch4;
  logic signed [11:0] mv;
  logic signed [15:0] mx, my;
  logic signed [16:0] my_neg;

  always_comb begin
    turn_armed_next = turn_armed; turn_count_next = turn_count;
    spin_sw_seen_next = spin_sw_seen; spin_sw_last_next = spin_sw_last;
    spin_sw_armed_next = spin_sw_armed; wheel_ready_next = wheel_ready;
    wheel_spin_sel_next = wheel_spin_sel; left_sw_last_next = left_sw_last;
    keys_seen_next = keys_seen; keys_last_next = keys_last;
    kb_active_next = kb_active; kb_mode_next = kb_mode;
    kb_g_rel_next = kb_g_rel; kb_spin_armed_next = kb_spin_armed;
    kb_q_rel_next = kb_q_rel; kb_f_rel_next = kb_f_rel;
    kb_friction_next = kb_friction;
    pressed = '0;
    online = 1'b0;
    mode = rima_pkg::MODE_OFF;
    kb_before = rima_pkg::MODE_OFF;
    wheel12 = 12'(dial_wheel);
    ch4 = 12'(dial_wheel);
    mv = 12'(mv_normal);
    mx = mouse_dx;
    my = mouse_dy;
    my_neg = '0;
    f = '0;
    f.yaw = stick_right_x; f.pitch = stick_right_y; f.strafe = stick_left_x;
    f.forward = stick_left_y; f.wheel = dial_wheel;

    if (link_online) begin
      online = 1'b1;
      if (keys_seen) pressed = key_bitmap & ~keys_last;
      keys_seen_next = 1'b1;
      keys_last_next = key_bitmap;
      if (pressed[rima_pkg::KEY_V]) begin
        kb_active_next = ~kb_active;
        kb_g_rel_next = 1'b0; kb_spin_armed_next = 1'b0; kb_q_rel_next = 1'b0;
        kb_f_rel_next = 1'b0; kb_friction_next = 1'b0;
        kb_mode_next = rima_pkg::MODE_OFF;
      end
      if (left_switch == 2'(FOLLOW_POS)) mode = rima_pkg::MODE_FOLLOW;
      else if (left_switch == 2'(MECH_POS) || left_switch == 2'(MECH_DOWN_POS))
        mode = rima_pkg::MODE_MECH;
      else online = 1'b0;

      if (online) begin
        if (left_switch != left_sw_last) begin
          left_sw_last_next = left_switch;
          wheel_spin_sel_next = 1'b0;
          wheel_ready_next = 1'b0;
        end
        if (kb_active_next) begin
          wheel_spin_sel_next = 1'b0;
          wheel_ready_next = 1'b0;
        end else begin
          if (wheel12 >= -$signed({2'b0, spin_rearm}) && wheel12 <= $signed({2'b0, spin_rearm}))
            wheel_ready_next = 1'b1;
          else if (wheel_ready_next && wheel12 >= $signed({2'b0, spin_trig})) begin
            wheel_ready_next = 1'b0;
            if (wheel_spin_sel_next) wheel_spin_sel_next = 1'b0;
            else if (right_switch == rima_pkg::SW_DOWN) wheel_spin_sel_next = 1'b1;
          end
          if (wheel_spin_sel_next) mode = rima_pkg::MODE_SPIN;
        end

        if (kb_active_next) begin
          if (kb_mode_next == rima_pkg::MODE_OFF) kb_mode_next = mode;
          kb_before = kb_mode_next;
          if (pressed[rima_pkg::KEY_Z]) kb_mode_next = rima_pkg::MODE_FOLLOW;
          else if (pressed[rima_pkg::KEY_X]) kb_mode_next = rima_pkg::MODE_MECH;
          else if (pressed[rima_pkg::KEY_C] && !kb_friction_next)
            kb_mode_next = rima_pkg::MODE_SPIN;
          if (key_bitmap[rima_pkg::KEY_CTRL]) mv = 12'(mv_slow);
          else if (key_bitmap[rima_pkg::KEY_SHIFT]) mv = 12'(mv_sprint);
          f.forward = 11'((key_bitmap[rima_pkg::KEY_W] ? mv : 12'sd0)
                        - (key_bitmap[rima_pkg::KEY_S] ? mv : 12'sd0));
          f.strafe = 11'((key_bitmap[rima_pkg::KEY_D] ? mv : 12'sd0)
                       - (key_bitmap[rima_pkg::KEY_A] ? mv : 12'sd0));
          if (mouse_right_button) begin
            mx = aim_div(mouse_dx);
            my = aim_div(mouse_dy);
          end
          my_neg = -17'(my);
          f.kb_map = 1'b1;
          f.mx_prod = 24'(mx * $signed({1'b0, yaw_gain}));
          f.my_prod = 24'(my_neg * PITCH_GAIN);
          f.wheel = '0;
          if (!key_bitmap[rima_pkg::KEY_Q]) kb_q_rel_next = 1'b1;
          if (kb_q_rel_next && key_bitmap[rima_pkg::KEY_Q]) f.wheel = -11'sd660;
          mode = kb_mode_next;
          if (kb_mode_next != kb_before) begin
            kb_g_rel_next = 1'b0;
            kb_spin_armed_next = 1'b0;
            if (kb_mode_next == rima_pkg::MODE_SPIN || kb_before == rima_pkg::MODE_SPIN) begin
              kb_f_rel_next = 1'b0;
              kb_friction_next = 1'b0;
            end
          end
          if (kb_mode_next == rima_pkg::MODE_SPIN) begin
            if (!key_bitmap[rima_pkg::KEY_G]) kb_g_rel_next = 1'b1;
            if (kb_g_rel_next && pressed[rima_pkg::KEY_G])
              kb_spin_armed_next = ~kb_spin_armed_next;
            f.spin = kb_spin_armed_next;
            kb_f_rel_next = 1'b0;
            kb_friction_next = 1'b0;
          end else begin
            if (!key_bitmap[rima_pkg::KEY_F]) kb_f_rel_next = 1'b1;
            if (kb_f_rel_next && pressed[rima_pkg::KEY_F])
              kb_friction_next = ~kb_friction_next;
          end
        end

        if (!kb_active_next && mode == rima_pkg::MODE_SPIN
            && right_switch != rima_pkg::SW_INVALID) begin
          if (spin_sw_seen && right_switch != spin_sw_last) spin_sw_armed_next = 1'b1;
          spin_sw_seen_next = 1'b1;
          spin_sw_last_next = right_switch;
          f.spin = spin_sw_armed_next && right_switch == 2'(SPIN_ON_POS);
        end else begin
          spin_sw_seen_next = 1'b0;
          spin_sw_last_next = '0;
          spin_sw_armed_next = 1'b0;
        end

        ch4 = 12'(f.wheel);
        if (ch4 > -$signed({2'b0, turn_rearm})) turn_armed_next = 1'b1;
        else if (turn_armed && ch4 <= -$signed({2'b0, turn_trig})) begin
          turn_armed_next = 1'b0;
          turn_count_next = turn_count + 32'd1;
        end
      end
    end

    if (!online) begin
      turn_armed_next = 1'b0; spin_sw_seen_next = 1'b0; spin_sw_last_next = '0;
      spin_sw_armed_next = 1'b0; wheel_ready_next = 1'b0; wheel_spin_sel_next = 1'b0;
      left_sw_last_next = '0; keys_seen_next = 1'b0; keys_last_next = '0;
      kb_active_next = 1'b0; kb_mode_next = rima_pkg::MODE_OFF;
      kb_g_rel_next = 1'b0; kb_spin_armed_next = 1'b0; kb_q_rel_next = 1'b0;
      kb_f_rel_next = 1'b0; kb_friction_next = 1'b0;
      f = '0;
      mode = rima_pkg::MODE_OFF;
    end
    f.online = online;
    f.mode = mode;
    f.kb_on = online && kb_active_next;
    f.turns = turn_count_next;
  end

endmodule

>>> sv/rima_back.sv
module rima_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  rima_pkg::frame_t   frame,
  output logic               full,
  output logic               valid,
  input  logic               ready,
  output logic               out_online,
  output logic [1:0]         chassis_mode,
  output logic signed [10:0] out_yaw,
  output logic signed [10:0] out_pitch,
  output logic signed [10:0] out_strafe,
  output logic signed [10:0] out_forward,
  output logic signed [10:0] out_wheel,
  output logic               rotate_enable,
  output logic               keyboard_mode_on,
  output logic [31:0]        turnaround_total
);

  // two-entry queue of front records
  rima_pkg::frame_t q [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       pop;
  rima_pkg::frame_t h;

  assign valid = cnt != 2'd0;
  assign full  = cnt == 2'd2;
  assign pop   = valid && ready;
  assign h     = q[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= '0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q[wp] <= frame;
  end

  function automatic logic signed [10:0] clamp660(input logic signed [23:0] v);
    if (v > 24'sd660) return 11'sd660;
    if (v < -24'sd660) return -11'sd660;
    return 11'(v);
  endfunction

  always_comb begin
    out_online = h.online;
    chassis_mode = h.mode;
    out_yaw = h.kb_map ? clamp660(h.mx_prod) : h.yaw;
    out_pitch = h.kb_map ? clamp660(h.my_prod) : h.pitch;
    out_strafe = h.strafe;
    out_forward = h.forward;
    out_wheel = h.wheel;
    rotate_enable = h.spin;
    keyboard_mode_on = h.kb_on;
    turnaround_total = h.turns;
  end

endmodule

>>> sv/rima_checker.sv
module rima_sva (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_online,
  input logic [1:0]  chassis_mode,
  input logic        rotate_enable,
  input logic        keyboard_mode_on,
  input logic [10:0] out_yaw,
  input logic [10:0] out_wheel
);

  a_offline_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_online |-> chassis_mode == rima_pkg::MODE_OFF)
    else $error("offline result with nonzero mode");

  a_offline_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_online |-> !rotate_enable && !keyboard_mode_on
      && out_yaw == '0 && out_wheel == '0)
    else $error("offline result with live channels");

  a_spin_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && rotate_enable |-> chassis_mode == rima_pkg::MODE_SPIN)
    else $error("spin enabled outside spin mode");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(chassis_mode))
    else $error("stalled result changed");

endmodule

bind remote_input_mode_arbiter rima_sva u_rima_sva (
  .clk, .rst, .out_valid, .out_ready, .out_online, .chassis_mode,
  .rotate_enable, .keyboard_mode_on, .out_yaw, .out_wheel
);
